@@ hw/rtl/scan_tear_detector_assert.svh @@
// Assertion helpers for the scan tear detector; expect clk and rst in scope.
`ifndef SCAN_TEAR_DETECTOR_ASSERT_SVH
`define SCAN_TEAR_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCANTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan tear detector check failed");

// Consequent must hold in the cycle after the antecedent.
`define SCANTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan tear detector check failed");

`endif

@@ hw/rtl/scantd_pkg.sv @@
`default_nettype none
package scantd_pkg;

  localparam int LINE_W   = 12;
  localparam int PERIOD_W = 24;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = LINE_W + PERIOD_W;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [LINE_W-1:0]   LINES_RESET     = 12'd516;
  localparam logic [PERIOD_W-1:0] MIN_DELTA_RESET = 24'd1000;
  localparam logic [PERIOD_W-1:0] MAX_DELTA_RESET = 24'd200000;

  localparam logic CMD_VSYNC = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    REG_LINES     = 2'd0,
    REG_MIN_DELTA = 2'd1,
    REG_MAX_DELTA = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LINE_W-1:0]   lines;
    logic [PERIOD_W-1:0] min_delta;
    logic [PERIOD_W-1:0] max_delta;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/scan_tear_detector.sv @@
// Scan tear detector.
// Input channel (in_valid/in_ready) takes one request: cmd 0 is a vsync event
// with vsync_time, cmd 1 is a flush check with flush_start, flush_end and the
// row span row_first..row_last. Each request gives one result on the output
// channel (out_valid/out_ready): tore, period_estimate and vsync_total.
// A vsync passes through a subtract and an update state. A flush check with
// a known period makes two scan line lookups, each a modulo and a division
// on the shared restoring divider at one quotient bit a cycle. A flush
// lasting a full period or with no period known skips the lookups. One
// request is in flight at a time; in_ready is high only while the
// sequencer is idle.
// The result sits in an output register, so in_ready returns as soon as the
// result is loaded; if the receiver stalls with a result pending, the next
// request is worked and then waits for the output register to free.
// The APB port sets lines_per_frame (0x0), min_delta_us (0x4) and
// max_delta_us (0x8); write it only while the block is idle.
// Synchronous reset clears the period (unknown), the last vsync time, the
// vsync count and any pending result, and restores the register defaults.
`default_nettype none
module scan_tear_detector
  import scantd_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  cmd,
  input  wire logic [TIME_WIDTH-1:0] vsync_time,
  input  wire logic [TIME_WIDTH-1:0] flush_start,
  input  wire logic [TIME_WIDTH-1:0] flush_end,
  input  wire logic [LINE_W-1:0]     row_first,
  input  wire logic [LINE_W-1:0]     row_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       tore,
  output logic      [PERIOD_W-1:0]   period_estimate,
  output logic      [COUNT_W-1:0]    vsync_total
);

  `include "scan_tear_detector_assert.svh"

  localparam int DIV_W = (TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_VSUB, S_VUPD, S_DSUB, S_DCMP, S_ISUB, S_MSTART,
    S_MWAIT, S_MUL, S_QSTART, S_QWAIT, S_CMP, S_DONE
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic [TIME_WIDTH-1:0] time_a;
  logic [TIME_WIDTH-1:0] time_b;
  logic [LINE_W-1:0]     y1;
  logic [LINE_W-1:0]     y2;
  logic [TIME_WIDTH-1:0] last_vsync;
  logic [PERIOD_W-1:0]   frame_period;
  logic [COUNT_W-1:0]    vsync_counter;
  logic                  tore_r;
  logic                  sel;
  logic [TIME_WIDTH:0]   diff;
  logic [PERIOD_W-1:0]   into;
  logic [PROD_W-1:0]     prod;
  logic [LINE_W-1:0]     line0;
  logic [LINE_W-1:0]     line1;

  logic [TIME_WIDTH-1:0] sub_a;
  logic [TIME_WIDTH-1:0] sub_b;
  logic                  borrow;
  logic                  diff_hi;
  logic [PERIOD_W-1:0]   diff_lo;
  logic [PERIOD_W+2:0]   avg_sum;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  div_stat_t             div_stat;
  logic [DIV_W-1:0]      div_quot;
  logic [PERIOD_W-1:0]   div_rem;

  scantd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scantd_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_period),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_ready = (state == S_IDLE);

  // Shared wide subtractor operands.
  always_comb begin
    unique case (state)
      S_DSUB: begin
        sub_a = time_b;
        sub_b = time_a;
      end
      S_ISUB: begin
        sub_a = sel ? time_b : time_a;
        sub_b = last_vsync;
      end
      default: begin
        sub_a = time_a;
        sub_b = last_vsync;
      end
    endcase
  end

  assign borrow  = diff[TIME_WIDTH];
  assign diff_hi = |diff[TIME_WIDTH-1:PERIOD_W];
  assign diff_lo = diff[PERIOD_W-1:0];
  assign avg_sum = {frame_period, 3'b000} - {3'b000, frame_period} + {3'b000, diff_lo};

  assign div_start    = (state == S_MSTART) || (state == S_QSTART);
  // Clamp a time before the last vsync to zero.
  assign div_dividend = (state == S_MSTART)
                      ? (borrow ? '0 : DIV_W'(diff[TIME_WIDTH-1:0]))
                      : DIV_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_vsync    <= '0;
      frame_period  <= '0;
      vsync_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Drop the taken result unless a new one is loaded at this edge.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            time_a <= (cmd == CMD_FLUSH) ? flush_start : vsync_time;
            time_b <= flush_end;
            y1     <= row_first;
            y2     <= row_last;
            tore_r <= 1'b0;
            sel    <= 1'b0;
            if (cmd == CMD_VSYNC) begin
              state <= S_VSUB;
            end else if (frame_period == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_DSUB;
            end
          end
        end
        S_VSUB: begin
          diff  <= {1'b0, sub_a} - {1'b0, sub_b};
          state <= S_VUPD;
        end
        S_VUPD: begin
          if (!borrow && !diff_hi && diff_lo > cfg.min_delta && diff_lo < cfg.max_delta) begin
            frame_period <= (frame_period == '0) ? diff_lo : avg_sum[PERIOD_W+2:3];
          end
          last_vsync    <= time_a;
          vsync_counter <= vsync_counter + COUNT_W'(1);
          state         <= S_DONE;
        end
        S_DSUB: begin
          diff  <= {1'b0, sub_a} - {1'b0, sub_b};
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (!borrow && (diff_hi || diff_lo >= frame_period)) begin
            tore_r <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_ISUB;
          end
        end
        S_ISUB: begin
          diff  <= {1'b0, sub_a} - {1'b0, sub_b};
          state <= S_MSTART;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (div_stat.done) begin
            into  <= div_rem;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(into) * PROD_W'(cfg.lines);
          state <= S_QSTART;
        end
        S_QSTART: state <= S_QWAIT;
        S_QWAIT: begin
          if (div_stat.done) begin
            if (sel) begin
              line1 <= div_quot[LINE_W-1:0];
              state <= S_CMP;
            end else begin
              line0 <= div_quot[LINE_W-1:0];
              sel   <= 1'b1;
              state <= S_ISUB;
            end
          end
        end
        S_CMP: begin
          // Swept lines wrap through vsync when the end line is below the start line.
          if (line0 <= line1) begin
            tore_r <= !(line1 < y1 || line0 > y2);
          end else begin
            tore_r <= (line0 <= y2) || (line1 >= y1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            tore            <= tore_r;
            period_estimate <= frame_period;
            vsync_total     <= vsync_counter;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCANTD_ASSERT_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready)
  `SCANTD_ASSERT_NOW(a_div_done_waited, div_stat.done, state == S_MWAIT || state == S_QWAIT)
  `SCANTD_ASSERT_NOW(a_idle_div_free, in_ready, !div_stat.busy)
  `SCANTD_ASSERT_NOW(a_no_tear_unknown, out_valid && period_estimate == '0, !tore)
  `SCANTD_ASSERT_NEXT(a_vsync_counts, state == S_VUPD,
                      vsync_counter == $past(vsync_counter) + COUNT_W'(1))

endmodule
`default_nettype wire

@@ hw/rtl/scantd_cfg.sv @@
`default_nettype none
module scantd_cfg
  import scantd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lines     <= LINES_RESET;
      cfg.min_delta <= MIN_DELTA_RESET;
      cfg.max_delta <= MAX_DELTA_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_LINES:     cfg.lines     <= pwdata[LINE_W-1:0];
        REG_MIN_DELTA: cfg.min_delta <= pwdata[PERIOD_W-1:0];
        REG_MAX_DELTA: cfg.max_delta <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LINES:     prdata = APB_DW'(cfg.lines);
      REG_MIN_DELTA: prdata = APB_DW'(cfg.min_delta);
      REG_MAX_DELTA: prdata = APB_DW'(cfg.max_delta);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/scantd_div.sv @@
`default_nettype none
module scantd_div
  import scantd_pkg::*;
#(
  parameter int DIV_W = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DIV_W-1:0]    dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  output div_stat_t                stat,
  output logic      [DIV_W-1:0]    quot,
  output logic      [PERIOD_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]    cnt;
  logic [PERIOD_W-1:0] den;
  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W:0]   trial;
  logic                ge;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign shifted = {rem, quot[DIV_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(DIV_W);
        quot      <= dividend;
        rem       <= '0;
        den       <= divisor;
      end else if (stat.busy) begin
        rem  <= ge ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
        quot <= {quot[DIV_W-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ verif/scan_tear_scoreboard.sv @@
`timescale 1ns / 100ps
module scan_tear_scoreboard
  import scantd_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  cmd,
  input  logic [TIME_WIDTH-1:0] vsync_time,
  input  logic [TIME_WIDTH-1:0] flush_start,
  input  logic [TIME_WIDTH-1:0] flush_end,
  input  logic [LINE_W-1:0]     row_first,
  input  logic [LINE_W-1:0]     row_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  tore,
  input  logic [PERIOD_W-1:0]   period_estimate,
  input  logic [COUNT_W-1:0]    vsync_total,
  output int                    mismatch_count,
  output int                    results_owed
);

  typedef struct packed {
    logic                torn;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  vsyncs;
  } detector_result_t;

  cfg_t                  regs;
  logic [TIME_WIDTH-1:0] last_vsync;
  logic [PERIOD_W-1:0]   period;
  logic [COUNT_W-1:0]    vsyncs;
  detector_result_t      owed_q[$];

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Scan line at time t; time before the last vsync counts as line 0.
  function automatic logic [LINE_W-1:0] scan_row(input logic [TIME_WIDTH-1:0] t);
    logic [63:0] into;
    into = (t > last_vsync) ? 64'(t - last_vsync) : 64'd0;
    into = into % 64'(period);
    return LINE_W'((into * 64'(regs.lines)) / 64'(period));
  endfunction

  function automatic logic flush_torn(input logic [TIME_WIDTH-1:0] t0, t1,
                                      input logic [LINE_W-1:0] y1, y2);
    logic [LINE_W-1:0] l0, l1;
    if (period == '0) return 1'b0;
    if (t1 >= t0 && (t1 - t0) >= period) return 1'b1;
    l0 = scan_row(t0);
    l1 = scan_row(t1);
    if (l0 <= l1) return !(l1 < y1 || l0 > y2);
    // scan wrapped through vsync during the flush
    return (l0 <= y2) || (l1 >= y1);
  endfunction

  function automatic detector_result_t accept_request();
    logic [TIME_WIDTH-1:0] delta;
    logic [63:0]           blended;
    detector_result_t      r;
    r.torn = 1'b0;
    if (cmd == CMD_VSYNC) begin
      if (vsync_time > last_vsync) begin
        delta = vsync_time - last_vsync;
        if (delta > regs.min_delta && delta < regs.max_delta) begin
          if (period == '0) begin
            period = PERIOD_W'(delta);
          end else begin
            blended = (64'(period) * 64'd7 + 64'(delta)) / 64'd8;
            period = PERIOD_W'(blended);
          end
        end
      end
      last_vsync = vsync_time;
      vsyncs = vsyncs + 1'b1;
    end else begin
      r.torn = flush_torn(flush_start, flush_end, row_first, row_last);
    end
    r.period = period;
    r.vsyncs = vsyncs;
    return r;
  endfunction

  always @(posedge clk) begin
    detector_result_t got, want;
    if (rst) begin
      regs = '{lines: LINES_RESET, min_delta: MIN_DELTA_RESET, max_delta: MAX_DELTA_RESET};
      last_vsync = '0;
      period = '0;
      vsyncs = '0;
      owed_q.delete();
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {tore, period_estimate, vsync_total};
        if (owed_q.size() == 0) begin
          report($sformatf("unexpected result: tore %0b period %0d vsyncs %0d",
                           got.torn, got.period, got.vsyncs));
        end else begin
          want = owed_q.pop_front();
          if (got.torn !== want.torn)
            report($sformatf("tore %0b, predicted %0b", got.torn, want.torn));
          if (got.period !== want.period)
            report($sformatf("period_estimate %0d, predicted %0d", got.period, want.period));
          if (got.vsyncs !== want.vsyncs)
            report($sformatf("vsync_total %0d, predicted %0d", got.vsyncs, want.vsyncs));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          APB_AW'({REG_LINES, 2'b00}):     regs.lines = pwdata[LINE_W-1:0];
          APB_AW'({REG_MIN_DELTA, 2'b00}): regs.min_delta = pwdata[PERIOD_W-1:0];
          APB_AW'({REG_MAX_DELTA, 2'b00}): regs.max_delta = pwdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) owed_q.push_back(accept_request());
      results_owed <= owed_q.size();
    end
  end

endmodule

@@ verif/scan_tear_detector_tb.sv @@
`timescale 1ns / 100ps
module scan_tear_detector_tb;
  import scantd_pkg::*;

  localparam int TW = 48;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 250;
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = 4'hC;
  localparam logic [TW-1:0] LOCK_TIME = 48'd218167;
  localparam int FIRST_PERIOD = 16667;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic in_valid, in_ready, cmd;
  logic [TW-1:0] vsync_time, flush_start, flush_end;
  logic [LINE_W-1:0] row_first, row_last;
  logic out_valid, out_ready, tore;
  logic [PERIOD_W-1:0] period_estimate;
  logic [COUNT_W-1:0] vsync_total;
  int mismatch_count, results_owed;

  logic [TW-1:0] vsync_base;
  logic [LINE_W-1:0] top_row;
  bit bursts_on = 1'b1;
  int cycle_count;

  scan_tear_detector #(.TIME_WIDTH(TW)) DUT (.*);

  scan_tear_scoreboard #(.TIME_WIDTH(TW)) scoreboard (.*);

  always #6 clk = ~clk;

  function automatic logic [TW-1:0] rand_time();
    return TW'({$urandom, $urandom});
  endfunction

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_t r);
    return APB_AW'({r, 2'b00});
  endfunction

  // Hold valid and payload until the request is taken.
  task automatic push_request(input logic c, input logic [TW-1:0] vt, fs, fe,
                              input logic [LINE_W-1:0] rf, rl);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd <= c;
    vsync_time <= vt;
    flush_start <= fs;
    flush_end <= fe;
    row_first <= rf;
    row_last <= rl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_vsync(input logic [TW-1:0] t);
    vsync_base = t;
    push_request(CMD_VSYNC, t, rand_time(), rand_time(), LINE_W'($urandom),
                 LINE_W'($urandom));
  endtask

  task automatic send_flush(input logic [TW-1:0] t0, t1, input logic [LINE_W-1:0] y1, y2);
    push_request(CMD_FLUSH, rand_time(), t0, t1, y1, y2);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Upper data bits are random; the register keeps only its own width.
  task automatic configure(input logic [LINE_W-1:0] lines,
                           input logic [PERIOD_W-1:0] lo, hi);
    logic [APB_DW-1:0] data;
    data = $urandom;
    data[LINE_W-1:0] = lines;
    apb_write(reg_addr(REG_LINES), data);
    data = $urandom;
    data[PERIOD_W-1:0] = lo;
    apb_write(reg_addr(REG_MIN_DELTA), data);
    data = $urandom;
    data[PERIOD_W-1:0] = hi;
    apb_write(reg_addr(REG_MAX_DELTA), data);
    top_row = (lines == '0) ? '1 : lines - 1'b1;
  endtask

  // Mostly regular vsync cadence with flushes around it; the rest is noise.
  task automatic random_request(input int unsigned nom);
    int unsigned pick;
    logic [TW-1:0] t0;
    logic [LINE_W-1:0] a, b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_vsync(vsync_base + nom - nom / 16 + $urandom_range(0, nom / 8));
    end else if (pick < 80) begin
      t0 = vsync_base + $urandom_range(0, 2 * nom);
      a = LINE_W'($urandom_range(0, top_row));
      b = LINE_W'($urandom_range(a, top_row));
      if ($urandom_range(0, 9) == 0)
        send_flush(t0, t0 + $urandom_range(0, nom + nom / 4), b, a);
      else
        send_flush(t0, t0 + $urandom_range(0, nom + nom / 4), a, b);
    end else if (pick < 88) begin
      send_flush(rand_time(), rand_time(), LINE_W'($urandom), LINE_W'($urandom));
    end else if (pick < 95) begin
      send_vsync(vsync_base - $urandom_range(0, nom));
    end else if (pick < 97) begin
      send_vsync(vsync_base + $urandom_range(1, nom / 4));
    end else begin
      send_vsync(rand_time());
    end
  endtask

  task automatic run_phase(input int count, input int unsigned nom);
    repeat (count) random_request(nom);
    drain();
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned nom;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = CMD_VSYNC;
    vsync_time = '0;
    flush_start = '0;
    flush_end = '0;
    row_first = '0;
    row_last = '0;
    vsync_base = '0;
    top_row = LINES_RESET - 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_flush(48'd100, 48'd200, '0, '1);          // no period known yet
    send_vsync('0);                                  // same time as stored
    send_vsync(48'd500);                             // delta below the floor
    send_vsync(48'd1500);                            // delta equal to the floor
    send_vsync(48'd201500);                          // delta equal to the ceiling
    send_vsync(LOCK_TIME);                           // first accepted delta
    send_flush(LOCK_TIME + 100, LOCK_TIME + 100 + FIRST_PERIOD, 12'd600, 12'd700);
    send_flush(LOCK_TIME + 100, LOCK_TIME + 99 + FIRST_PERIOD, 12'd600, 12'd700);
    send_flush(LOCK_TIME + 10000, LOCK_TIME + 9000, '0, '1);  // end before start
    send_flush(LOCK_TIME - 5000, LOCK_TIME + 200, 12'd0, 12'd10);
    send_flush(LOCK_TIME + 2000, LOCK_TIME + 4000, 12'd300, 12'd100);
    send_flush(LOCK_TIME + 16000, LOCK_TIME + FIRST_PERIOD + 500, 12'd510, 12'd515);
    send_vsync(LOCK_TIME + 16600);
    send_vsync(LOCK_TIME);                           // time runs backwards
    send_vsync(LOCK_TIME + 16700);
    send_flush(LOCK_TIME + 20000, LOCK_TIME + 20001, '1, '1);
    send_flush('1, '1, '0, '0);
    send_vsync('1);
    send_flush('0, '1, '0, '1);
    send_vsync('0);
    drain();

    configure('1, '0, '1);
    run_phase(100, $urandom_range(2000, 40000));

    configure(12'd1, '1, '0);
    apb_write(UNMAPPED_ADDR, $urandom);
    run_phase(60, $urandom_range(2000, 40000));

    configure('0, 24'd500, 24'd100000);
    nom = $urandom_range(2000, 40000);
    repeat (30) random_request(nom);
    drain();
    run_phase(30, nom);

    configure(12'd1125, 24'd2000, 24'd80000);
    run_phase(120, $urandom_range(3000, 40000));

    configure(LINE_W'($urandom_range(1, 4095)), PERIOD_W'($urandom_range(0, 5000)),
              PERIOD_W'($urandom_range(50000, 16777215)));
    run_phase(80, $urandom_range(6000, 40000));

    bursts_on = 1'b0;
    configure(LINE_W'($urandom_range(1, 4095)), 24'd1000, 24'd200000);
    run_phase(80, $urandom_range(5000, 60000));

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
